### rtl/core/y86ex_pkg.sv
// Package for the Y86-64 execute stage: word types, instruction, ALU and
// condition codes, flag register type. No dependencies.
package y86ex_pkg;

  localparam int unsigned DataWidthDef = 64;
  localparam int unsigned WordWidth    = 64;

  localparam logic [3:0] RegNone = 4'hF;

  typedef enum logic [3:0] {
    IcHalt   = 4'd0,
    IcNop    = 4'd1,
    IcCmov   = 4'd2,
    IcIrmov  = 4'd3,
    IcRmmov  = 4'd4,
    IcMrmov  = 4'd5,
    IcOpq    = 4'd6,
    IcJxx    = 4'd7,
    IcCall   = 4'd8,
    IcRet    = 4'd9,
    IcPush   = 4'd10,
    IcPop    = 4'd11
  } icode_e;

  typedef enum logic [3:0] {
    FnAdd = 4'd0,
    FnSub = 4'd1,
    FnAnd = 4'd2,
    FnXor = 4'd3
  } alu_fn_e;

  typedef enum logic [3:0] {
    CondAlways = 4'd0,
    CondLe     = 4'd1,
    CondLt     = 4'd2,
    CondEq     = 4'd3,
    CondNe     = 4'd4,
    CondGe     = 4'd5,
    CondGt     = 4'd6
  } cond_e;

  localparam logic [1:0] StatOk = 2'd0;

  typedef struct packed {
    logic zf;
    logic sf;
    logic of;
  } flags_t;

  typedef struct packed {
    logic   known;
    flags_t flags;
  } alu_status_t;

  typedef struct packed {
    logic [1:0]                  stat;
    logic [3:0]                  icode;
    logic [3:0]                  ifun;
    logic signed [WordWidth-1:0] val_a;
    logic signed [WordWidth-1:0] val_b;
    logic signed [WordWidth-1:0] val_c;
    logic [3:0]                  dest_e;
    logic [3:0]                  dest_m;
    logic [1:0]                  mem_stage_stat;
    logic [1:0]                  wb_stage_stat;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                  out_stat;
    logic [3:0]                  out_icode;
    logic                        cond_taken;
    logic signed [WordWidth-1:0] val_e;
    logic signed [WordWidth-1:0] out_val_a;
    logic [3:0]                  out_dest_e;
    logic [3:0]                  out_dest_m;
    logic                        bubble_mem;
  } out_word_t;

endpackage

### rtl/core/y86ex_alu.sv
// ALU of the execute stage: operand selection, add/sub/and/xor at
// DATA_WIDTH bits, new flag values. Depends on y86ex_pkg.
module y86ex_alu #(
  parameter int unsigned DATA_WIDTH = y86ex_pkg::DataWidthDef
) (
  input  logic [3:0]                             icode_i,
  input  logic [3:0]                             ifun_i,
  input  logic signed [y86ex_pkg::WordWidth-1:0] val_a_i,
  input  logic signed [y86ex_pkg::WordWidth-1:0] val_b_i,
  input  logic signed [y86ex_pkg::WordWidth-1:0] val_c_i,
  output logic signed [y86ex_pkg::WordWidth-1:0] val_e_o,
  output y86ex_pkg::alu_status_t                 status_o
);

  logic [DATA_WIDTH-1:0] op_a, op_b, res;
  logic [3:0]            fn;
  logic                  ovf;
  logic                  known;

  always_comb begin
    case (icode_i)
      y86ex_pkg::IcCmov, y86ex_pkg::IcOpq: op_a = val_a_i[DATA_WIDTH-1:0];
      y86ex_pkg::IcIrmov, y86ex_pkg::IcRmmov,
      y86ex_pkg::IcMrmov:                  op_a = val_c_i[DATA_WIDTH-1:0];
      y86ex_pkg::IcCall, y86ex_pkg::IcPush: op_a = DATA_WIDTH'(-8);
      y86ex_pkg::IcRet, y86ex_pkg::IcPop:   op_a = DATA_WIDTH'(8);
      default:                              op_a = '0;
    endcase
  end

  always_comb begin
    case (icode_i)
      y86ex_pkg::IcRmmov, y86ex_pkg::IcMrmov, y86ex_pkg::IcOpq,
      y86ex_pkg::IcCall, y86ex_pkg::IcRet, y86ex_pkg::IcPush,
      y86ex_pkg::IcPop: op_b = val_b_i[DATA_WIDTH-1:0];
      default:          op_b = '0;
    endcase
  end

  assign fn = (icode_i == y86ex_pkg::IcOpq) ? ifun_i : y86ex_pkg::FnAdd;

  always_comb begin
    known = 1'b1;
    ovf   = 1'b0;
    case (fn)
      y86ex_pkg::FnAdd: begin
        res = op_a + op_b;
        ovf = (op_a[DATA_WIDTH-1] == op_b[DATA_WIDTH-1]) &&
              (res[DATA_WIDTH-1] != op_a[DATA_WIDTH-1]);
      end
      y86ex_pkg::FnSub: begin
        res = op_b - op_a;
        ovf = (op_a[DATA_WIDTH-1] != op_b[DATA_WIDTH-1]) &&
              (res[DATA_WIDTH-1] != op_b[DATA_WIDTH-1]);
      end
      y86ex_pkg::FnAnd: res = op_a & op_b;
      y86ex_pkg::FnXor: res = op_a ^ op_b;
      default: begin
        res   = '0;
        known = 1'b0;
      end
    endcase
  end

  assign val_e_o           = y86ex_pkg::WordWidth'($signed(res));
  assign status_o.known    = known;
  assign status_o.flags.zf = (res == '0);
  assign status_o.flags.sf = res[DATA_WIDTH-1];
  assign status_o.flags.of = ovf;

endmodule

### rtl/core/y86ex_cond.sv
// Jump / conditional-move condition evaluation from the flag register.
// Depends on y86ex_pkg.
module y86ex_cond (
  input  logic [3:0]        icode_i,
  input  logic [3:0]        ifun_i,
  input  y86ex_pkg::flags_t flags_i,
  output logic              taken_o
);

  logic lt, sel;

  assign lt = flags_i.sf ^ flags_i.of;

  always_comb begin
    case (ifun_i)
      y86ex_pkg::CondAlways: sel = 1'b1;
      y86ex_pkg::CondLe:     sel = lt | flags_i.zf;
      y86ex_pkg::CondLt:     sel = lt;
      y86ex_pkg::CondEq:     sel = flags_i.zf;
      y86ex_pkg::CondNe:     sel = ~flags_i.zf;
      y86ex_pkg::CondGe:     sel = ~lt;
      y86ex_pkg::CondGt:     sel = ~lt & ~flags_i.zf;
      default:               sel = 1'b0;
    endcase
  end

  assign taken_o = sel &&
                   ((icode_i == y86ex_pkg::IcCmov) || (icode_i == y86ex_pkg::IcJxx));

endmodule

### rtl/core/y86_pipeline_execute_stage.sv
// Top level of the Y86-64 execute stage: input register, ALU, condition
// logic, flag register and result register. Depends on y86ex_pkg,
// y86ex_alu and y86ex_cond.
//
// Input channel in_valid_i / in_ready_o carries one in_word_t per
// instruction; output channel out_valid_o / out_ready_i carries one
// out_word_t per instruction, in order.
// Path: an accepted word is held in the input register, then passes through the
// ALU and condition logic into the result register.
// Throughput: one word per cycle while out_ready_i does not hold a result, set by
// the single pass from input register to result register; the flag register is read and written in that pass.
// Reset: both stages empty, ZF set, SF and OF clear.
// Stall: a result waiting on out_ready_i holds; the input register still
// takes a word while it is empty, after which in_ready_o drops until the
// result is taken.
module y86_pipeline_execute_stage #(
  parameter int unsigned DATA_WIDTH = y86ex_pkg::DataWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  y86ex_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output y86ex_pkg::out_word_t out_word_o
);

  logic                 s1_valid_q, out_valid_q;
  y86ex_pkg::in_word_t  s1_q;
  y86ex_pkg::out_word_t out_q, out_d;
  y86ex_pkg::flags_t    flags_q, flags_d;

  logic                                  s1_adv, in_acc;
  logic                                  taken, later_exc;
  logic signed [y86ex_pkg::WordWidth-1:0] val_e;
  y86ex_pkg::alu_status_t                alu_st;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  y86ex_alu #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_alu (
    .icode_i (s1_q.icode),
    .ifun_i  (s1_q.ifun),
    .val_a_i (s1_q.val_a),
    .val_b_i (s1_q.val_b),
    .val_c_i (s1_q.val_c),
    .val_e_o (val_e),
    .status_o(alu_st)
  );

  y86ex_cond u_cond (
    .icode_i(s1_q.icode),
    .ifun_i (s1_q.ifun),
    .flags_i(flags_q),
    .taken_o(taken)
  );

  assign later_exc = (s1_q.mem_stage_stat != y86ex_pkg::StatOk) ||
                     (s1_q.wb_stage_stat != y86ex_pkg::StatOk);

  always_comb begin
    flags_d = flags_q;
    if (s1_adv && (s1_q.icode == y86ex_pkg::IcOpq) && alu_st.known && !later_exc) begin
      flags_d = alu_st.flags;
    end
  end

  always_comb begin
    out_d.out_stat   = s1_q.stat;
    out_d.out_icode  = s1_q.icode;
    out_d.cond_taken = taken;
    out_d.val_e      = val_e;
    out_d.out_val_a  = s1_q.val_a;
    out_d.out_dest_e = ((s1_q.icode == y86ex_pkg::IcCmov) && !taken) ?
                       y86ex_pkg::RegNone : s1_q.dest_e;
    out_d.out_dest_m = s1_q.dest_m;
    out_d.bubble_mem = later_exc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '{zf: 1'b1, sf: 1'b0, of: 1'b0};
    end else begin
      flags_q <= flags_d;
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (!out_valid_q || out_ready_i) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_word_i;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_adv && (s1_q.icode == y86ex_pkg::IcOpq)) |=> $stable(flags_q))
    else $error("flags changed without an OPq leaving the input register");

  a_cmov_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.out_icode == y86ex_pkg::IcCmov) && !out_q.cond_taken)
    |-> (out_q.out_dest_e == y86ex_pkg::RegNone))
    else $error("failed cmov kept its destination");

  a_cond_icode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.cond_taken) |->
    ((out_q.out_icode == y86ex_pkg::IcCmov) || (out_q.out_icode == y86ex_pkg::IcJxx)))
    else $error("condition taken for an instruction without a condition");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input held off while a stage is free");

endmodule

### tb/y86ex_exec_checker.sv
`timescale 1ns / 100ps
// Checker for the Y86-64 execute stage: watches both channels, predicts each
// result word from its own flag register and compares field by field.
// Depends on y86ex_pkg.
module y86ex_exec_checker import y86ex_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_word_t    in_word_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_word_t   out_word_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o
);

  localparam logic [63:0] StackDown = 64'hFFFF_FFFF_FFFF_FFF8;
  localparam logic [63:0] StackUp   = 64'd8;

  logic      flag_z;
  logic      flag_s;
  logic      flag_o;
  out_word_t mem_reg_q[$];
  out_word_t want;
  out_word_t next_word;

  initial mismatch_count_o = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("%0t: %s got %h expected %h", $time, what, got, exp_val);
    mismatch_count_o++;
  endtask

  // one instruction through operand select, ALU, condition and flag update
  task automatic execute_instr(input in_word_t w, output out_word_t r);
    logic [63:0] mask;
    logic [63:0] sbit;
    logic [63:0] opa;
    logic [63:0] opb;
    logic [63:0] res;
    logic [3:0]  fn;
    logic        lt;
    logic        taken;
    logic        ovf;
    logic        known;
    logic        late_exc;
    mask  = {64{1'b1}} >> (64 - DATA_WIDTH);
    sbit  = 64'h1 << (DATA_WIDTH - 1);
    lt    = flag_s ^ flag_o;
    taken = 1'b0;
    if (w.icode == IcCmov || w.icode == IcJxx) begin
      case (w.ifun)
        CondAlways: taken = 1'b1;
        CondLe:     taken = lt | flag_z;
        CondLt:     taken = lt;
        CondEq:     taken = flag_z;
        CondNe:     taken = ~flag_z;
        CondGe:     taken = ~lt;
        CondGt:     taken = ~lt & ~flag_z;
        default:    taken = 1'b0;
      endcase
    end
    case (w.icode)
      IcCmov, IcOpq:           opa = w.val_a;
      IcIrmov, IcRmmov, IcMrmov: opa = w.val_c;
      IcCall, IcPush:          opa = StackDown;
      IcRet, IcPop:            opa = StackUp;
      default:                 opa = '0;
    endcase
    case (w.icode)
      IcRmmov, IcMrmov, IcOpq, IcCall, IcRet, IcPush, IcPop: opb = w.val_b;
      default: opb = '0;
    endcase
    opa   = opa & mask;
    opb   = opb & mask;
    fn    = (w.icode == IcOpq) ? w.ifun : FnAdd;
    known = 1'b1;
    ovf   = 1'b0;
    case (fn)
      FnAdd: begin
        res = (opa + opb) & mask;
        ovf = (((opa ^ opb) & sbit) == 0) && (((res ^ opa) & sbit) != 0);
      end
      FnSub: begin
        res = (opb - opa) & mask;
        ovf = (((opa ^ opb) & sbit) != 0) && (((res ^ opb) & sbit) != 0);
      end
      FnAnd:   res = opa & opb;
      FnXor:   res = opa ^ opb;
      default: begin
        res   = '0;
        known = 1'b0;
      end
    endcase
    late_exc = (w.mem_stage_stat != StatOk) || (w.wb_stage_stat != StatOk);
    if (w.icode == IcOpq && known && !late_exc) begin
      flag_z = (res == 0);
      flag_s = (res & sbit) != 0;
      flag_o = ovf;
    end
    r.out_stat   = w.stat;
    r.out_icode  = w.icode;
    r.cond_taken = taken;
    r.val_e      = ((res & sbit) != 0) ? (res | ~mask) : res;
    r.out_val_a  = w.val_a;
    r.out_dest_e = (w.icode == IcCmov && !taken) ? RegNone : w.dest_e;
    r.out_dest_m = w.dest_m;
    r.bubble_mem = late_exc;
  endtask

  task automatic check_word(input out_word_t got, input out_word_t exp_w);
    if (got.out_stat !== exp_w.out_stat)
      report_mismatch("out_stat", got.out_stat, exp_w.out_stat);
    if (got.out_icode !== exp_w.out_icode)
      report_mismatch("out_icode", got.out_icode, exp_w.out_icode);
    if (got.cond_taken !== exp_w.cond_taken)
      report_mismatch("cond_taken", got.cond_taken, exp_w.cond_taken);
    if (got.val_e !== exp_w.val_e)
      report_mismatch("val_e", got.val_e, exp_w.val_e);
    if (got.out_val_a !== exp_w.out_val_a)
      report_mismatch("out_val_a", got.out_val_a, exp_w.out_val_a);
    if (got.out_dest_e !== exp_w.out_dest_e)
      report_mismatch("out_dest_e", got.out_dest_e, exp_w.out_dest_e);
    if (got.out_dest_m !== exp_w.out_dest_m)
      report_mismatch("out_dest_m", got.out_dest_m, exp_w.out_dest_m);
    if (got.bubble_mem !== exp_w.bubble_mem)
      report_mismatch("bubble_mem", got.bubble_mem, exp_w.bubble_mem);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_z = 1'b1;
      flag_s = 1'b0;
      flag_o = 1'b0;
      mem_reg_q.delete();
      pending_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (mem_reg_q.size() == 0) begin
          report_mismatch("unexpected result word, val_e", out_word_i.val_e, '0);
        end else begin
          want = mem_reg_q.pop_front();
          check_word(out_word_i, want);
        end
      end
      if (in_valid_i && in_ready_i) begin
        execute_instr(in_word_i, next_word);
        mem_reg_q.push_back(next_word);
      end
      pending_count_o <= mem_reg_q.size();
    end
  end

endmodule

### tb/y86_pipeline_execute_stage_tb.sv
`timescale 1ns / 100ps
// Testbench top for the Y86-64 execute stage: clock, reset, directed and
// random instruction words, random stalls and the verdict.
// Depends on y86ex_pkg, y86_pipeline_execute_stage and y86ex_exec_checker.
module y86_pipeline_execute_stage_tb;
  import y86ex_pkg::*;

  localparam int unsigned NumRandom = 1250;
  localparam int unsigned IdlePct   = 17;
  localparam logic [63:0] SMin      = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SMax      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] AllOnes   = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;
  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned sent = 0;
  in_word_t    directed_q[$];

  always #2 clk_i = ~clk_i;

  y86_pipeline_execute_stage DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  y86ex_exec_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_word_i        (in_word),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_word_i       (out_word),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  function automatic logic quiet_now();
    return sent >= 400 && sent < 700;
  endfunction

  always @(negedge clk_i) begin
    out_ready <= quiet_now() || ($urandom_range(0, 99) >= IdlePct);
  end

  function automatic in_word_t mk_instr(logic [1:0] st, logic [3:0] ic, logic [3:0] fn,
                                        logic [63:0] a, logic [63:0] b, logic [63:0] c,
                                        logic [3:0] de, logic [3:0] dm,
                                        logic [1:0] ms, logic [1:0] ws);
    in_word_t w;
    w.stat           = st;
    w.icode          = ic;
    w.ifun           = fn;
    w.val_a          = a;
    w.val_b          = b;
    w.val_c          = c;
    w.dest_e         = de;
    w.dest_m         = dm;
    w.mem_stage_stat = ms;
    w.wb_stage_stat  = ws;
    return w;
  endfunction

  function automatic logic [63:0] rand_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return AllOnes;
      2:       return SMin;
      3:       return SMax;
      4:       return 64'($urandom_range(0, 16)) - 64'd8;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_word_t rand_instr();
    in_word_t w;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    w.stat           = ($urandom_range(0, 9) < 8) ? StatOk : 2'($urandom_range(0, 3));
    w.val_a          = rand_operand();
    w.val_b          = ($urandom_range(0, 4) == 0) ? w.val_a : rand_operand();
    w.val_c          = rand_operand();
    w.dest_e         = 4'($urandom_range(0, 15));
    w.dest_m         = 4'($urandom_range(0, 15));
    w.mem_stage_stat = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3)) : StatOk;
    w.wb_stage_stat  = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3)) : StatOk;
    if (sel < 8) begin
      w.icode = 4'($urandom_range(0, 15));
      w.ifun  = 4'($urandom_range(0, 15));
    end else if (sel < 40) begin
      w.icode = IcOpq;
      w.ifun  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(FnAdd, FnXor));
    end else if (sel < 70) begin
      w.icode = ($urandom_range(0, 1) == 0) ? IcCmov : IcJxx;
      w.ifun  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(CondAlways, CondGt));
    end else begin
      w.icode = 4'($urandom_range(IcHalt, IcPop));
      w.ifun  = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
    end
    return w;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_instr(input in_word_t w);
    while (!quiet_now() && $urandom_range(0, 99) < IdlePct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (!in_ready);
    sent++;
    @(negedge clk_i);
  endtask

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    // flags start ZF=1: taken eq, then signed overflow on add and sub
    directed_q.push_back(mk_instr(StatOk, IcHalt, 0, 0, 0, 0, 0, 0, StatOk, StatOk));
    directed_q.push_back(mk_instr(StatOk, IcJxx, CondEq, 0, 0, 0, 1, 2, StatOk, StatOk));
    directed_q.push_back(mk_instr(StatOk, IcOpq, FnAdd, 1, SMax, 0, 3, RegNone,
                                  StatOk, StatOk));
    directed_q.push_back(mk_instr(StatOk, IcJxx, CondLt, 0, 0, 0, 0, 0, StatOk, StatOk));
    directed_q.push_back(mk_instr(StatOk, IcCmov, CondGe, AllOnes, 0, 0, 4, 5,
                                  StatOk, StatOk));
    directed_q.push_back(mk_instr(StatOk, IcOpq, FnSub, 1, SMin, 0, 6, 7, StatOk, StatOk));
    directed_q.push_back(mk_instr(StatOk, IcCmov, CondLe, SMax, 0, 0, 8, 9, StatOk, StatOk));
    directed_q.push_back(mk_instr(StatOk, IcCmov, CondGt, SMin, 0, 0, 10, 11,
                                  StatOk, StatOk));
    directed_q.push_back(mk_instr(StatOk, IcOpq, FnAnd, AllOnes, 0, 0, 12, 13,
                                  StatOk, StatOk));
    // later stage in exception: no flag update, bubble
    directed_q.push_back(mk_instr(2'd1, IcOpq, FnXor, AllOnes, 5, 0, 14, 15, 2'd3, StatOk));
    directed_q.push_back(mk_instr(2'd2, IcOpq, FnXor, 7, 7, 0, 0, 0, StatOk, 2'd2));
    directed_q.push_back(mk_instr(StatOk, IcJxx, CondNe, 0, 0, 0, 0, 0, StatOk, StatOk));
    directed_q.push_back(mk_instr(2'd3, IcOpq, 4'hF, AllOnes, AllOnes, AllOnes,
                                  RegNone, RegNone, 2'd3, 2'd3));
    directed_q.push_back(mk_instr(StatOk, IcJxx, CondAlways, 0, 0, 0, 0, 0, StatOk, StatOk));
    directed_q.push_back(mk_instr(StatOk, IcCmov, 4'hF, 1, 2, 3, 9, 9, StatOk, StatOk));
    directed_q.push_back(mk_instr(StatOk, IcJxx, 4'd7, 0, 0, 0, 0, 0, StatOk, StatOk));
    directed_q.push_back(mk_instr(StatOk, IcIrmov, 0, SMin, SMax, SMax, 1, 1,
                                  StatOk, StatOk));
    directed_q.push_back(mk_instr(StatOk, IcRmmov, 0, 0, SMax, 1, 2, 2, StatOk, StatOk));
    directed_q.push_back(mk_instr(StatOk, IcMrmov, 0, 0, SMin, AllOnes, 3, 3,
                                  StatOk, StatOk));
    directed_q.push_back(mk_instr(StatOk, IcCall, 0, 0, 0, 0, 4, 4, StatOk, StatOk));
    directed_q.push_back(mk_instr(StatOk, IcRet, 0, 0, AllOnes, 0, 5, 5, StatOk, StatOk));
    directed_q.push_back(mk_instr(StatOk, IcPush, 0, 0, SMin, 0, 6, 6, StatOk, StatOk));
    directed_q.push_back(mk_instr(StatOk, IcPop, 0, 0, SMax, 0, 7, 7, StatOk, StatOk));
    directed_q.push_back(mk_instr(StatOk, IcNop, 4'hF, SMax, SMax, SMax, 8, 8,
                                  StatOk, StatOk));
    directed_q.push_back(mk_instr(StatOk, 4'hF, 4'hF, AllOnes, AllOnes, AllOnes, 0, 0,
                                  StatOk, StatOk));
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed_q[i]) send_instr(directed_q[i]);
    repeat (NumRandom) send_instr(rand_instr());
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
